// ----- hdl/lobm_pkg.sv -----
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants of the order book matcher
// Transaction structs, command and report codes, cell search token.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int MAX_ORDERS = 32;
    localparam int IDX_W      = $clog2(MAX_ORDERS);
    localparam int ID_W       = 32;
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int ARR_W      = 32;
    localparam int TRD_W      = 32;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_CANCEL  = 2'd1;
    localparam logic [1:0] CMD_REPLACE = 2'd2;
    localparam logic [1:0] CMD_RSVD    = 2'd3;

    localparam logic SIDE_BUY = 1'b0;

    localparam logic [1:0] TIF_DAY = 2'd0;
    localparam logic [1:0] TIF_GTC = 2'd1;
    localparam logic [1:0] TIF_IOC = 2'd2;
    localparam logic [1:0] TIF_FOK = 2'd3;

    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_PARTIAL  = 3'd1;
    localparam logic [2:0] ST_FILLED   = 3'd2;
    localparam logic [2:0] ST_CANCELED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;

    localparam logic [1:0] RR_NONE  = 2'd0;
    localparam logic [1:0] RR_DUP   = 2'd1;
    localparam logic [1:0] RR_NOLIQ = 2'd2;
    localparam logic [1:0] RR_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [ID_W-1:0]    ord_ref;
        logic               side;
        logic               order_kind;
        logic [1:0]         tif;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } t_in;

    typedef struct packed {
        logic               is_trade;
        logic               last;
        logic [ID_W-1:0]    ord_ref_res;
        logic [ID_W-1:0]    rest_ord_ref;
        logic [TRD_W-1:0]   exec_seq;
        logic [PRICE_W-1:0] price_res;
        logic [QTY_W-1:0]   quantity_res;
        logic [QTY_W-1:0]   cum_qty;
        logic [QTY_W-1:0]   open_qty;
        logic [2:0]         status;
        logic [1:0]         rej_code;
    } t_out;

    // search parameters broadcast to every cell
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               side;
        logic               market;
        logic [PRICE_W-1:0] price;
        logic [ARR_W-1:0]   arr_ctr;
    } t_srch;

    // token passed down the chain, one cell per cycle
    typedef struct packed {
        logic               vld;
        logic               dup_hit;
        logic [IDX_W-1:0]   dup_idx;
        logic               dup_side;
        logic [PRICE_W-1:0] dup_price;
        logic [QTY_W-1:0]   dup_open;
        logic [QTY_W-1:0]   dup_filled;
        logic               free_hit;
        logic [IDX_W-1:0]   free_idx;
        logic [QTY_W-1:0]   avail;
        logic               best_hit;
        logic [IDX_W-1:0]   best_idx;
        logic [ID_W-1:0]    best_id;
        logic [PRICE_W-1:0] best_price;
        logic [QTY_W-1:0]   best_open;
        logic [ARR_W-1:0]   best_age;
    } t_tok;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_KILL,
        UPD_FILL,
        UPD_LOAD
    } t_upd_op;

    typedef struct packed {
        t_upd_op            op;
        logic [IDX_W-1:0]   idx;
        logic [ID_W-1:0]    id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [QTY_W-1:0]   filled;
        logic [ARR_W-1:0]   arr;
    } t_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    typedef enum logic [1:0] {
        PH_LOOKUP,
        PH_FIRST,
        PH_NEXT
    } t_phase;

    typedef enum logic [3:0] {
        DEC_NONE,
        DEC_NOTFOUND,
        DEC_CANCEL,
        DEC_REPLACE,
        DEC_DUP,
        DEC_NOLIQ,
        DEC_FILLED,
        DEC_TRADE,
        DEC_IOC,
        DEC_REST,
        DEC_FULL
    } t_dec;

endpackage

// ----- hdl/limit_order_book_matcher.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_matcher: one-symbol price-time priority matching engine
// Resting orders live in a chain of cells; a search token walks the chain.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel i_in_valid / i_in / o_in_stall carries add, cancel and
//  cancel-replace commands; a transaction completes when valid is high and
//  stall is low. Output channel o_out_valid / o_out / i_out_stall returns
//  the trade results of a command followed by one execution report (last=1).
//  Every decision rests on a scan in which a token passes one cell per
//  cycle. Each trade that leaves a remainder adds another scan, a trade
//  that completes the order is followed by its report with no new scan,
//  and a replace adds one more scan for its re-add.
//  A reserved command code is taken and dropped with no result.
//  The next command is taken as soon as the report sits in the output
//  register, even while the receiver still stalls it; with the receiver
//  stalling, the sequencer holds before producing its next result.
//  Synchronous reset empties the book and clears the arrival and trade
//  counters; the first trade carries trade number zero.
// ----------------------------------------------------------------------------
module limit_order_book_matcher (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lobm_pkg::t_in  i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output lobm_pkg::t_out o_out,
    input  logic           i_out_stall
);

    lobm_pkg::t_srch w_srch;
    lobm_pkg::t_upd  w_upd;
    lobm_pkg::t_tok  w_tok [0:lobm_pkg::MAX_ORDERS];

    lobm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .o_srch      (w_srch),
        .o_upd       (w_upd),
        .o_tok       (w_tok[0]),
        .i_tok       (w_tok[lobm_pkg::MAX_ORDERS])
    );

    for (genvar g = 0; g < lobm_pkg::MAX_ORDERS; g++) begin : g_cell
        lobm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (lobm_pkg::IDX_W'(g)),
            .i_srch  (w_srch),
            .i_upd   (w_upd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule

// ----- hdl/lobm_cell.sv -----
// ----------------------------------------------------------------------------
// lobm_cell: one resting order slot of the book
// Holds one entry, folds it into the passing search token and applies
// updates addressed to its index.
// ----------------------------------------------------------------------------
module lobm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [lobm_pkg::IDX_W-1:0] i_idx,
    input  lobm_pkg::t_srch       i_srch,
    input  lobm_pkg::t_upd        i_upd,
    input  lobm_pkg::t_tok        i_tok,
    output lobm_pkg::t_tok        o_tok
);

    logic                          r_valid;
    logic [lobm_pkg::ID_W-1:0]     r_id;
    logic                          r_side;
    logic [lobm_pkg::PRICE_W-1:0]  r_price;
    logic [lobm_pkg::QTY_W-1:0]    r_open;
    logic [lobm_pkg::QTY_W-1:0]    r_filled;
    logic [lobm_pkg::ARR_W-1:0]    r_arr;
    lobm_pkg::t_tok                r_tok;
    lobm_pkg::t_tok                n_tok;

    logic [lobm_pkg::ARR_W-1:0]    w_age;
    logic                          w_cross;
    logic                          w_pbetter;
    logic                          w_better;
    logic [lobm_pkg::QTY_W:0]      w_sum;
    logic                          w_sel;

    assign w_age   = i_srch.arr_ctr - r_arr;
    assign w_cross = r_valid && (r_side != i_srch.side) &&
                     (i_srch.market ||
                      ((i_srch.side == lobm_pkg::SIDE_BUY) ? (r_price <= i_srch.price)
                                                          : (r_price >= i_srch.price)));
    assign w_pbetter = (i_srch.side == lobm_pkg::SIDE_BUY) ? (r_price < i_tok.best_price)
                                                         : (r_price > i_tok.best_price);
    assign w_better = !i_tok.best_hit ||
                      ((r_price != i_tok.best_price) ? w_pbetter : (w_age > i_tok.best_age));
    assign w_sum = {1'b0, i_tok.avail} + {1'b0, r_open};
    assign w_sel = (i_upd.op != lobm_pkg::UPD_NONE) && (i_upd.idx == i_idx);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.dup_hit && r_valid && (r_id == i_srch.id)) begin
            n_tok.dup_hit    = 1'b1;
            n_tok.dup_idx    = i_idx;
            n_tok.dup_side   = r_side;
            n_tok.dup_price  = r_price;
            n_tok.dup_open   = r_open;
            n_tok.dup_filled = r_filled;
        end
        if (!i_tok.free_hit && !r_valid) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = i_idx;
        end
        if (w_cross) begin
            // saturating sum, only compared against the order quantity
            n_tok.avail = w_sum[lobm_pkg::QTY_W] ? '1 : w_sum[lobm_pkg::QTY_W-1:0];
            if (w_better) begin
                n_tok.best_hit   = 1'b1;
                n_tok.best_idx   = i_idx;
                n_tok.best_id    = r_id;
                n_tok.best_price = r_price;
                n_tok.best_open  = r_open;
                n_tok.best_age   = w_age;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_sel) begin
                case (i_upd.op)
                    lobm_pkg::UPD_KILL: begin
                        r_valid <= 1'b0;
                    end
                    lobm_pkg::UPD_FILL: begin
                        r_valid <= (r_open != i_upd.qty);
                    end
                    lobm_pkg::UPD_LOAD: begin
                        r_valid <= 1'b1;
                    end
                    default: begin
                        r_valid <= r_valid;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && (i_upd.op == lobm_pkg::UPD_FILL)) begin
            r_open   <= r_open - i_upd.qty;
            r_filled <= r_filled + i_upd.qty;
        end else if (w_sel && (i_upd.op == lobm_pkg::UPD_LOAD)) begin
            r_id     <= i_upd.id;
            r_side   <= i_upd.side;
            r_price  <= i_upd.price;
            r_open   <= i_upd.qty;
            r_filled <= i_upd.filled;
            r_arr    <= i_upd.arr;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- hdl/lobm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lobm_ctrl: command sequencer of the order book matcher
// Launches chain scans, decides trades and reports from the scan result,
// issues cell updates and holds the output register.
// ----------------------------------------------------------------------------
module lobm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  lobm_pkg::t_in   i_in,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output lobm_pkg::t_out  o_out,
    input  logic            i_out_stall,
    output lobm_pkg::t_srch o_srch,
    output lobm_pkg::t_upd  o_upd,
    output lobm_pkg::t_tok  o_tok,
    input  lobm_pkg::t_tok  i_tok
);

    lobm_pkg::t_state               r_state;
    lobm_pkg::t_state               n_state;
    lobm_pkg::t_phase               r_phase;
    logic [1:0]                     r_cmd;
    logic [lobm_pkg::ID_W-1:0]      r_id;
    logic                           r_side;
    logic                           r_mkt;
    logic [1:0]                     r_tif;
    logic [lobm_pkg::PRICE_W-1:0]   r_price;
    logic [lobm_pkg::QTY_W-1:0]     r_qty;
    logic [lobm_pkg::QTY_W-1:0]     r_rem;
    lobm_pkg::t_tok                 r_res;
    logic                           r_inj_vld;
    logic [lobm_pkg::ARR_W-1:0]     r_arr_ctr;
    logic [lobm_pkg::TRD_W-1:0]     r_trd_ctr;
    lobm_pkg::t_out                 r_o;
    logic                           r_o_vld;

    logic                           w_accept;
    logic                           w_start;
    logic                           w_out_free;
    lobm_pkg::t_dec                 w_dec;
    logic [lobm_pkg::QTY_W-1:0]     w_filled;
    logic [lobm_pkg::QTY_W-1:0]     w_m;
    logic                           w_emit;
    lobm_pkg::t_out                 w_o;

    assign w_accept   = i_in_valid && (r_state == lobm_pkg::S_IDLE);
    assign w_start    = w_accept && (i_in.cmd != lobm_pkg::CMD_RSVD);
    assign w_out_free = !r_o_vld || !i_out_stall;
    assign w_filled   = r_qty - r_rem;
    assign w_m        = (r_rem < r_res.best_open) ? r_rem : r_res.best_open;
    assign w_emit     = (w_dec != lobm_pkg::DEC_NONE) && (w_dec != lobm_pkg::DEC_REPLACE);

    // decision on the latched scan result
    always_comb begin
        w_dec = lobm_pkg::DEC_NONE;
        if ((r_state == lobm_pkg::S_DECIDE) && w_out_free) begin
            if (r_phase == lobm_pkg::PH_LOOKUP) begin
                if (!r_res.dup_hit) begin
                    w_dec = lobm_pkg::DEC_NOTFOUND;
                end else if (r_cmd == lobm_pkg::CMD_CANCEL) begin
                    w_dec = lobm_pkg::DEC_CANCEL;
                end else begin
                    w_dec = lobm_pkg::DEC_REPLACE;
                end
            end else if ((r_phase == lobm_pkg::PH_FIRST) && r_res.dup_hit) begin
                w_dec = lobm_pkg::DEC_DUP;
            end else if ((r_phase == lobm_pkg::PH_FIRST) && (r_tif == lobm_pkg::TIF_FOK) &&
                         (r_res.avail < r_qty)) begin
                w_dec = lobm_pkg::DEC_NOLIQ;
            end else if (r_rem == '0) begin
                w_dec = lobm_pkg::DEC_FILLED;
            end else if (r_res.best_hit) begin
                w_dec = lobm_pkg::DEC_TRADE;
            end else if (r_mkt || (r_tif == lobm_pkg::TIF_IOC) ||
                         (r_tif == lobm_pkg::TIF_FOK)) begin
                w_dec = lobm_pkg::DEC_IOC;
            end else if (r_res.free_hit) begin
                w_dec = lobm_pkg::DEC_REST;
            end else begin
                w_dec = lobm_pkg::DEC_FULL;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lobm_pkg::S_IDLE: begin
                if (w_start) begin
                    n_state = lobm_pkg::S_SCAN;
                end
            end
            lobm_pkg::S_SCAN: begin
                if (i_tok.vld) begin
                    n_state = lobm_pkg::S_DECIDE;
                end
            end
            lobm_pkg::S_DECIDE: begin
                if (w_dec == lobm_pkg::DEC_REPLACE) begin
                    n_state = lobm_pkg::S_SCAN;
                end else if (w_dec == lobm_pkg::DEC_TRADE) begin
                    n_state = (r_rem != w_m) ? lobm_pkg::S_SCAN : lobm_pkg::S_DECIDE;
                end else if (w_dec != lobm_pkg::DEC_NONE) begin
                    n_state = lobm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lobm_pkg::S_IDLE;
            end
        endcase
    end

    // result item and cell update
    always_comb begin
        w_o = '0;
        w_o.last         = 1'b1;
        w_o.ord_ref_res  = r_id;
        w_o.price_res    = r_price;
        w_o.quantity_res = r_qty;
        o_upd = '0;
        o_upd.op = lobm_pkg::UPD_NONE;
        case (w_dec)
            lobm_pkg::DEC_NOTFOUND: begin
                w_o.price_res    = '0;
                w_o.quantity_res = '0;
                w_o.status       = lobm_pkg::ST_REJECTED;
                w_o.rej_code     = lobm_pkg::RR_NONE;
            end
            lobm_pkg::DEC_CANCEL: begin
                w_o.price_res    = r_res.dup_price;
                w_o.quantity_res = r_res.dup_open + r_res.dup_filled;
                w_o.cum_qty      = r_res.dup_filled;
                w_o.status       = lobm_pkg::ST_CANCELED;
                o_upd.op  = lobm_pkg::UPD_KILL;
                o_upd.idx = r_res.dup_idx;
            end
            lobm_pkg::DEC_REPLACE: begin
                o_upd.op  = lobm_pkg::UPD_KILL;
                o_upd.idx = r_res.dup_idx;
            end
            lobm_pkg::DEC_DUP: begin
                w_o.status   = lobm_pkg::ST_REJECTED;
                w_o.rej_code = lobm_pkg::RR_DUP;
            end
            lobm_pkg::DEC_NOLIQ: begin
                w_o.status   = lobm_pkg::ST_REJECTED;
                w_o.rej_code = lobm_pkg::RR_NOLIQ;
            end
            lobm_pkg::DEC_FILLED: begin
                w_o.cum_qty = w_filled;
                w_o.status  = lobm_pkg::ST_FILLED;
            end
            lobm_pkg::DEC_TRADE: begin
                w_o.is_trade     = 1'b1;
                w_o.last         = 1'b0;
                w_o.rest_ord_ref = r_res.best_id;
                w_o.exec_seq     = r_trd_ctr;
                w_o.price_res    = r_res.best_price;
                w_o.quantity_res = w_m;
                o_upd.op  = lobm_pkg::UPD_FILL;
                o_upd.idx = r_res.best_idx;
                o_upd.qty = w_m;
            end
            lobm_pkg::DEC_IOC: begin
                w_o.cum_qty = w_filled;
                w_o.status  = (w_filled != '0) ? lobm_pkg::ST_PARTIAL
                                               : lobm_pkg::ST_CANCELED;
            end
            lobm_pkg::DEC_REST: begin
                w_o.cum_qty  = w_filled;
                w_o.open_qty = r_rem;
                w_o.status   = (w_filled != '0) ? lobm_pkg::ST_PARTIAL
                                                : lobm_pkg::ST_NEW;
                o_upd.op     = lobm_pkg::UPD_LOAD;
                o_upd.idx    = r_res.free_idx;
                o_upd.id     = r_id;
                o_upd.side   = r_side;
                o_upd.price  = r_price;
                o_upd.qty    = r_rem;
                o_upd.filled = w_filled;
                o_upd.arr    = r_arr_ctr;
            end
            lobm_pkg::DEC_FULL: begin
                w_o.cum_qty  = w_filled;
                w_o.status   = lobm_pkg::ST_REJECTED;
                w_o.rej_code = lobm_pkg::RR_FULL;
            end
            default: begin
                w_o.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lobm_pkg::S_IDLE;
            r_inj_vld <= 1'b0;
            r_o_vld   <= 1'b0;
            r_arr_ctr <= '0;
            r_trd_ctr <= '0;
        end else begin
            r_state   <= n_state;
            r_inj_vld <= w_start || (w_dec == lobm_pkg::DEC_REPLACE) ||
                         ((w_dec == lobm_pkg::DEC_TRADE) && (r_rem != w_m));
            if (w_emit) begin
                r_o_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
            if (w_dec == lobm_pkg::DEC_TRADE) begin
                r_trd_ctr <= r_trd_ctr + 1'b1;
            end
            if (w_dec == lobm_pkg::DEC_REST) begin
                r_arr_ctr <= r_arr_ctr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o <= w_o;
        end
        if ((r_state == lobm_pkg::S_SCAN) && i_tok.vld) begin
            r_res <= i_tok;
        end
        if (w_start) begin
            r_cmd   <= i_in.cmd;
            r_id    <= i_in.ord_ref;
            r_side  <= i_in.side;
            r_mkt   <= i_in.order_kind;
            r_tif   <= i_in.tif;
            r_price <= i_in.price;
            r_qty   <= i_in.quantity;
            r_rem   <= i_in.quantity;
            r_phase <= (i_in.cmd == lobm_pkg::CMD_ADD) ? lobm_pkg::PH_FIRST
                                                       : lobm_pkg::PH_LOOKUP;
        end else if (w_dec == lobm_pkg::DEC_REPLACE) begin
            // re-enter as a day limit add on the old side
            r_side  <= r_res.dup_side;
            r_mkt   <= 1'b0;
            r_tif   <= lobm_pkg::TIF_DAY;
            r_rem   <= r_qty;
            r_phase <= lobm_pkg::PH_FIRST;
        end else if (w_dec == lobm_pkg::DEC_TRADE) begin
            r_rem   <= r_rem - w_m;
            r_phase <= lobm_pkg::PH_NEXT;
        end
    end

    always_comb begin
        o_tok     = '0;
        o_tok.vld = r_inj_vld;
    end

    assign o_srch.id      = r_id;
    assign o_srch.side    = r_side;
    assign o_srch.market  = r_mkt;
    assign o_srch.price   = r_price;
    assign o_srch.arr_ctr = r_arr_ctr;

    assign o_in_stall  = (r_state != lobm_pkg::S_IDLE);
    assign o_out_valid = r_o_vld;
    assign o_out       = r_o;

endmodule

// ----- verif/lobm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_checker: scoreboard for the order book matcher
// Watches both channels, keeps its own copy of the book, predicts the trades
// and execution report of every accepted command and compares them in order.
// ----------------------------------------------------------------------------
module lobm_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lobm_pkg::t_in  i_in,
    input  logic           i_in_stall,
    input  logic           i_out_valid,
    input  lobm_pkg::t_out i_out,
    input  logic           i_out_stall,
    output int             o_fail_count,
    output int             o_pending
);

    // resting book
    bit                         bk_live   [lobm_pkg::MAX_ORDERS];
    logic [lobm_pkg::ID_W-1:0]  bk_id     [lobm_pkg::MAX_ORDERS];
    logic                       bk_side   [lobm_pkg::MAX_ORDERS];
    logic [31:0]                bk_price  [lobm_pkg::MAX_ORDERS];
    logic [31:0]                bk_open   [lobm_pkg::MAX_ORDERS];
    logic [31:0]                bk_filled [lobm_pkg::MAX_ORDERS];
    logic [31:0]                bk_arr    [lobm_pkg::MAX_ORDERS];
    logic [31:0]                arr_ctr;
    logic [31:0]                trade_ctr;

    lobm_pkg::t_out report_q[$];

    task automatic queue_result(bit trd, logic [31:0] id, logic [31:0] rid,
                                logic [31:0] tid, logic [31:0] px, logic [31:0] q,
                                logic [31:0] f, logic [31:0] l, logic [2:0] st,
                                logic [1:0] rr);
        lobm_pkg::t_out r;
        r.is_trade     = trd;
        r.last         = !trd;
        r.ord_ref_res  = id;
        r.rest_ord_ref = rid;
        r.exec_seq     = tid;
        r.price_res    = px;
        r.quantity_res = q;
        r.cum_qty      = f;
        r.open_qty     = l;
        r.status       = st;
        r.rej_code     = rr;
        report_q.insert(report_q.size(), r);
    endtask

    function automatic bit find_live(logic [31:0] id, output int idx);
        idx = -1;
        for (int i = 0; i < lobm_pkg::MAX_ORDERS; i++)
            if (idx < 0 && bk_live[i] && bk_id[i] == id) idx = i;
        return idx >= 0;
    endfunction

    function automatic bit crosses(int i, logic side, bit market, logic [31:0] px);
        if (!bk_live[i] || bk_side[i] == side) return 0;
        if (market) return 1;
        return (side == lobm_pkg::SIDE_BUY) ? (bk_price[i] <= px) : (bk_price[i] >= px);
    endfunction

    function automatic bit outranks(int a, int b, logic side);
        if (bk_price[a] != bk_price[b])
            return (side == lobm_pkg::SIDE_BUY) ? (bk_price[a] < bk_price[b])
                                                : (bk_price[a] > bk_price[b]);
        return (arr_ctr - bk_arr[a]) > (arr_ctr - bk_arr[b]);
    endfunction

    task automatic match_add(logic [31:0] id, logic side, bit market, logic [1:0] tif,
                             logic [31:0] px, logic [31:0] qty);
        logic [63:0] avail;
        logic [31:0] rem;
        logic [31:0] m;
        logic [31:0] filled;
        int          best;
        int          slot;
        if (find_live(id, slot)) begin
            queue_result(0, id, 0, 0, px, qty, 0, 0, lobm_pkg::ST_REJECTED,
                         lobm_pkg::RR_DUP);
            return;
        end
        if (tif == lobm_pkg::TIF_FOK) begin
            avail = 0;
            for (int i = 0; i < lobm_pkg::MAX_ORDERS; i++)
                if (crosses(i, side, market, px)) avail += bk_open[i];
            if (avail < qty) begin
                queue_result(0, id, 0, 0, px, qty, 0, 0, lobm_pkg::ST_REJECTED,
                             lobm_pkg::RR_NOLIQ);
                return;
            end
        end
        rem = qty;
        while (rem != 0) begin
            best = -1;
            for (int i = 0; i < lobm_pkg::MAX_ORDERS; i++)
                if (crosses(i, side, market, px) && (best < 0 || outranks(i, best, side)))
                    best = i;
            if (best < 0) break;
            m = (rem < bk_open[best]) ? rem : bk_open[best];
            queue_result(1, id, bk_id[best], trade_ctr, bk_price[best], m, 0, 0,
                         lobm_pkg::ST_NEW, lobm_pkg::RR_NONE);
            trade_ctr++;
            rem -= m;
            bk_open[best] -= m;
            bk_filled[best] += m;
            if (bk_open[best] == 0) bk_live[best] = 0;
        end
        filled = qty - rem;
        if (rem == 0) begin
            queue_result(0, id, 0, 0, px, qty, filled, 0, lobm_pkg::ST_FILLED,
                         lobm_pkg::RR_NONE);
        end else if (market || tif == lobm_pkg::TIF_IOC || tif == lobm_pkg::TIF_FOK) begin
            queue_result(0, id, 0, 0, px, qty, filled, 0,
                         (filled != 0) ? lobm_pkg::ST_PARTIAL : lobm_pkg::ST_CANCELED,
                         lobm_pkg::RR_NONE);
        end else begin
            slot = -1;
            for (int i = 0; i < lobm_pkg::MAX_ORDERS; i++)
                if (slot < 0 && !bk_live[i]) slot = i;
            if (slot < 0) begin
                queue_result(0, id, 0, 0, px, qty, filled, 0, lobm_pkg::ST_REJECTED,
                             lobm_pkg::RR_FULL);
            end else begin
                bk_live[slot]   = 1;
                bk_id[slot]     = id;
                bk_side[slot]   = side;
                bk_price[slot]  = px;
                bk_open[slot]   = rem;
                bk_filled[slot] = filled;
                bk_arr[slot]    = arr_ctr;
                arr_ctr++;
                queue_result(0, id, 0, 0, px, qty, filled, rem,
                             (filled != 0) ? lobm_pkg::ST_PARTIAL : lobm_pkg::ST_NEW,
                             lobm_pkg::RR_NONE);
            end
        end
    endtask

    task automatic predict_cmd(lobm_pkg::t_in c);
        int e;
        if (c.cmd == lobm_pkg::CMD_ADD) begin
            match_add(c.ord_ref, c.side, c.order_kind, c.tif, c.price, c.quantity);
        end else if (c.cmd == lobm_pkg::CMD_CANCEL || c.cmd == lobm_pkg::CMD_REPLACE) begin
            if (!find_live(c.ord_ref, e)) begin
                queue_result(0, c.ord_ref, 0, 0, 0, 0, 0, 0, lobm_pkg::ST_REJECTED,
                             lobm_pkg::RR_NONE);
            end else begin
                bk_live[e] = 0;
                if (c.cmd == lobm_pkg::CMD_CANCEL)
                    queue_result(0, c.ord_ref, 0, 0, bk_price[e], bk_open[e] + bk_filled[e],
                                 bk_filled[e], 0, lobm_pkg::ST_CANCELED, lobm_pkg::RR_NONE);
                else
                    match_add(c.ord_ref, bk_side[e], 0, lobm_pkg::TIF_DAY, c.price,
                              c.quantity);
            end
        end
        // reserved code: dropped silently
    endtask

    always @(posedge i_clk) begin
        lobm_pkg::t_out e;
        if (!i_rst_n) begin
            for (int i = 0; i < lobm_pkg::MAX_ORDERS; i++) bk_live[i] = 0;
            arr_ctr      = 0;
            trade_ctr    = 0;
            o_fail_count = 0;
            report_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (report_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result transaction: %p", i_out);
                end else begin
                    e = report_q.pop_front();
                    if (e.is_trade !== i_out.is_trade || e.last !== i_out.last ||
                        e.ord_ref_res !== i_out.ord_ref_res ||
                        e.rest_ord_ref !== i_out.rest_ord_ref ||
                        e.exec_seq !== i_out.exec_seq || e.price_res !== i_out.price_res ||
                        e.quantity_res !== i_out.quantity_res ||
                        e.cum_qty !== i_out.cum_qty ||
                        e.open_qty !== i_out.open_qty || e.status !== i_out.status ||
                        e.rej_code !== i_out.rej_code) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result mismatch\n  exp %p\n  act %p", e, i_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_cmd(i_in);
        end
        o_pending = report_q.size();
    end

endmodule

// ----- verif/limit_order_book_matcher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_tb: stimulus and verdict for the order book matcher
// Directed corner commands, then random book-building, crossing, cancel and
// replace traffic with idle and stall bursts; a checker does the scoring.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_tb;

    localparam int N_RANDOM   = 240;
    localparam int IDLE_LIMIT = 3000;

    logic           i_clk;
    logic           i_rst_n;
    logic           in_valid;
    lobm_pkg::t_in  in_cmd;
    logic           in_stall;
    logic           out_valid;
    lobm_pkg::t_out out_res;
    logic           out_stall;
    bit             quiet;
    int             fail_count;
    int             pending;
    int             idle_cycles;

    limit_order_book_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_cmd),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_res),
        .i_out_stall (out_stall)
    );

    lobm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in         (in_cmd),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out        (out_res),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall bursts
    initial begin
        out_stall = 0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                out_stall <= 0;
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(logic [1:0] cmd, logic [31:0] id, logic side, logic kind,
                        logic [1:0] tif, logic [31:0] px, logic [31:0] qty);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_valid        <= 1;
        in_cmd.cmd        <= cmd;
        in_cmd.ord_ref    <= id;
        in_cmd.side       <= side;
        in_cmd.order_kind <= kind;
        in_cmd.tif        <= tif;
        in_cmd.price      <= px;
        in_cmd.quantity   <= qty;
        do @(posedge i_clk); while (in_stall);
    endtask

    function automatic logic [31:0] pool_id();
        logic [5:0] low;
        low = 6'($urandom_range(0, 47));
        return {($urandom_range(0, 7) == 0) ? 26'h3FF_FFFF : 26'h0, low};
    endfunction

    initial begin
        int          r;
        logic        sd;
        logic [31:0] px;
        in_valid = 0;
        in_cmd   = '0;
        quiet    = 0;
        i_rst_n  = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed corners
        send(lobm_pkg::CMD_CANCEL, 5, 0, 0, lobm_pkg::TIF_DAY, 7, 7);     // unknown cancel
        send(lobm_pkg::CMD_REPLACE, 5, 0, 0, lobm_pkg::TIF_DAY, 7, 7);    // unknown replace
        send(lobm_pkg::CMD_RSVD, 5, 1, 1, lobm_pkg::TIF_FOK, 7, 7);       // dropped
        send(lobm_pkg::CMD_ADD, 1, 0, 0, lobm_pkg::TIF_DAY, 100, 10);
        send(lobm_pkg::CMD_ADD, 2, 0, 0, lobm_pkg::TIF_GTC, 100, 5);
        send(lobm_pkg::CMD_ADD, 1, 0, 0, lobm_pkg::TIF_DAY, 100, 10);     // duplicate id
        send(lobm_pkg::CMD_ADD, 3, 1, 0, lobm_pkg::TIF_FOK, 100, 20);     // fok short
        send(lobm_pkg::CMD_ADD, 4, 1, 0, lobm_pkg::TIF_IOC, 90, 20);      // ioc remainder
        send(lobm_pkg::CMD_ADD, 5, 0, 0, lobm_pkg::TIF_DAY, 100, 0);      // zero quantity
        send(lobm_pkg::CMD_ADD, 6, 1, 0, lobm_pkg::TIF_DAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(lobm_pkg::CMD_ADD, 7, 0, 1, lobm_pkg::TIF_IOC, 0, 3);        // market hit
        send(lobm_pkg::CMD_CANCEL, 6, 0, 0, lobm_pkg::TIF_DAY, 0, 0);
        send(lobm_pkg::CMD_ADD, 0, 0, 0, lobm_pkg::TIF_DAY, 0, 1);
        send(lobm_pkg::CMD_REPLACE, 0, 1, 1, lobm_pkg::TIF_IOC, 50, 7);
        send(lobm_pkg::CMD_ADD, 32'hFFFF_FFFF, 1, 1, lobm_pkg::TIF_FOK, 0, 32'hFFFF_FFFF);
        send(lobm_pkg::CMD_ADD, 8, 1, 1, lobm_pkg::TIF_DAY, 0, 10);       // market remainder
        send(lobm_pkg::CMD_ADD, 9, 0, 1, lobm_pkg::TIF_IOC, 4, 4);        // empty book
        send(lobm_pkg::CMD_ADD, 10, 0, 0, lobm_pkg::TIF_FOK, 200, 0);
        send(lobm_pkg::CMD_ADD, 11, 1, 1, lobm_pkg::TIF_GTC, 32'h8000_0000, 32'h7FFF_FFFF);

        // random traffic
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - 40) quiet = 1;
            r  = $urandom_range(0, 99);
            sd = $urandom_range(0, 1);
            if ((n >= 100 && n < 140) || r < 45) begin
                // passive order that rests on its own side
                px = sd ? $urandom_range(1001, 1100) : $urandom_range(900, 999);
                send(lobm_pkg::CMD_ADD, pool_id(), sd, 0, 2'($urandom_range(0, 1)), px,
                     $urandom_range(1, 50));
            end else if (r < 65) begin
                px = sd ? $urandom_range(900, 1000) : $urandom_range(1000, 1100);
                send(lobm_pkg::CMD_ADD, pool_id(), sd, ($urandom_range(0, 3) == 0),
                     2'($urandom_range(0, 3)), px, $urandom_range(1, 150));
            end else if (r < 80) begin
                send(lobm_pkg::CMD_CANCEL, pool_id(), sd, 0, lobm_pkg::TIF_DAY, 0, 0);
            end else if (r < 90) begin
                send(lobm_pkg::CMD_REPLACE, pool_id(), sd, 0, lobm_pkg::TIF_DAY,
                     $urandom_range(900, 1100), $urandom_range(1, 50));
            end else begin
                send(2'($urandom_range(0, 3)), ($urandom_range(0, 1) ? pool_id() : $urandom),
                     sd, 1'($urandom), 2'($urandom), $urandom, $urandom);
            end
        end
        @(negedge i_clk);
        in_valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- limit_order_book_matcher.f -----
hdl/lobm_pkg.sv
hdl/lobm_cell.sv
hdl/lobm_ctrl.sv
hdl/limit_order_book_matcher.sv
verif/lobm_checker.sv
verif/limit_order_book_matcher_tb.sv
